// ----- hdl/acs_pkg.sv -----
// ----------------------------------------------------------------------------
// acs_pkg
// Types, codes and defaults shared by the accumulator CPU step core.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 8;
  localparam int WORD_W   = 16;
  localparam int PC_W     = 9;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXEC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SKIP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  localparam logic [WORD_W-1:0] OP_NOP = 16'd0;
  localparam logic [WORD_W-1:0] OP_STA = 16'd16;
  localparam logic [WORD_W-1:0] OP_LDA = 16'd32;
  localparam logic [WORD_W-1:0] OP_ADD = 16'd48;
  localparam logic [WORD_W-1:0] OP_OR  = 16'd64;
  localparam logic [WORD_W-1:0] OP_AND = 16'd80;
  localparam logic [WORD_W-1:0] OP_NOT = 16'd96;
  localparam logic [WORD_W-1:0] OP_JMP = 16'd128;
  localparam logic [WORD_W-1:0] OP_JN  = 16'd144;
  localparam logic [WORD_W-1:0] OP_JZ  = 16'd160;
  localparam logic [WORD_W-1:0] OP_HLT = 16'd240;

  localparam logic [WORD_W-1:0] SIGN_MASK = 16'h8000;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] word_address;
    logic [WORD_W-1:0] word_data;
  } acs_req_t;

  typedef struct packed {
    logic [PC_W-1:0]     program_counter;
    logic [WORD_W-1:0]   accumulator;
    logic                zero_flag;
    logic                negative_flag;
    logic                stopped;
    logic [WORD_W-1:0]   read_word;
    logic [STATUS_W-1:0] step_status;
  } acs_rsp_t;

  typedef enum logic [1:0] {
    CLS_LOAD,
    CLS_STORE,
    CLS_PLAIN
  } acs_class_e;

  typedef enum logic [1:0] {
    RADDR_PC,
    RADDR_PC1,
    RADDR_EA
  } acs_raddr_e;

  typedef enum logic {
    WDATA_REQ,
    WDATA_ACC
  } acs_wdata_e;

  typedef struct packed {
    logic       accept;
    logic       mem_re;
    acs_raddr_e raddr_sel;
    logic       mem_we;
    acs_wdata_e wdata_sel;
    logic       ir_load;
    logic       opnd_load;
    logic       rd_load;
    logic       exec;
  } acs_ctl_t;

  typedef struct packed {
    logic       mod_done;
    logic       stopped;
    acs_class_e op_class;
  } acs_sts_t;

endpackage

// ----- hdl/acs_datapath.sv -----
// ----------------------------------------------------------------------------
// acs_datapath
// Word memory, CPU registers, address reduction unit and instruction execute.
// ----------------------------------------------------------------------------
module acs_datapath
  import acs_pkg::*;
#(
  parameter int MEM_DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  acs_req_t req_i,
  input  acs_ctl_t ctl_i,
  output acs_sts_t sts_o,
  output acs_rsp_t rsp_o
);

  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int PW  = $clog2(MEM_DEPTH + 1);
  localparam int MSM = 16 - $clog2(MEM_DEPTH);
  localparam bit IS_POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
  localparam logic [WORD_W:0] DIV_BASE = (WORD_W + 1)'(MEM_DEPTH);
  localparam logic [WORD_W:0] DIV_TOP  = DIV_BASE << MSM;
  localparam logic [PW:0]     PC_END   = (PW + 1)'(MEM_DEPTH);

  logic [WORD_W-1:0] mem_q [MEM_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  logic [PW-1:0]       pc_q, pc_d;
  logic [WORD_W-1:0]   acc_q, acc_d;
  logic                zero_q, zero_d;
  logic                neg_q, neg_d;
  logic                halt_q, halt_d;
  logic                mod_busy_q, mod_busy_d;

  logic [WORD_W-1:0]   ir_q;
  logic [WORD_W-1:0]   data_q;
  logic [WORD_W-1:0]   rd_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [WORD_W-1:0]   mod_q, mod_d;
  logic [WORD_W:0]     div_q, div_d;

  logic [PW:0]         pc_p1_w, pc_p2_w;
  logic [PW-1:0]       pc_adv1, pc_adv2;
  logic [AW-1:0]       ea, pc1_addr, raddr;
  logic [WORD_W-1:0]   wdata, mod_load_val;
  logic                stopped, mod_load;
  acs_class_e          op_class;

  assign pc_p1_w  = {1'b0, pc_q} + (PW + 1)'(1);
  assign pc_p2_w  = {1'b0, pc_q} + (PW + 1)'(2);
  assign pc_adv1  = (pc_p1_w > PC_END) ? PW'(MEM_DEPTH) : pc_p1_w[PW-1:0];
  assign pc_adv2  = (pc_p2_w > PC_END) ? PW'(MEM_DEPTH) : pc_p2_w[PW-1:0];
  assign pc1_addr = (pc_p1_w == PC_END) ? '0 : AW'(pc_p1_w);
  assign ea       = mod_q[AW-1:0];
  assign stopped  = halt_q | (pc_q >= PW'(MEM_DEPTH));

  always_comb begin
    case (ctl_i.raddr_sel)
      RADDR_PC:  raddr = AW'(pc_q);
      RADDR_PC1: raddr = pc1_addr;
      RADDR_EA:  raddr = ea;
      default:   raddr = ea;
    endcase
  end

  assign wdata = (ctl_i.wdata_sel == WDATA_ACC) ? acc_q : data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_we) begin
      mem_q[ea] <= wdata;
    end
    if (ctl_i.mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    case (ir_q)
      OP_LDA, OP_ADD, OP_OR, OP_AND: op_class = CLS_LOAD;
      OP_STA:                        op_class = CLS_STORE;
      default:                       op_class = CLS_PLAIN;
    endcase
  end

  // address reduction: mask, or restoring subtract of shifted depth
  assign mod_load     = ctl_i.accept | ctl_i.opnd_load;
  assign mod_load_val = ctl_i.accept ? WORD_W'(req_i.word_address) : rdata_q;

  always_comb begin
    mod_d      = mod_q;
    div_d      = div_q;
    mod_busy_d = mod_busy_q;
    if (mod_load) begin
      if (IS_POW2) begin
        mod_d      = mod_load_val & WORD_W'(MEM_DEPTH - 1);
        mod_busy_d = 1'b0;
      end else begin
        mod_d      = mod_load_val;
        mod_busy_d = 1'b1;
      end
      div_d = DIV_TOP;
    end else if (mod_busy_q) begin
      if ({1'b0, mod_q} >= div_q) begin
        mod_d = mod_q - div_q[WORD_W-1:0];
      end
      div_d      = div_q >> 1;
      mod_busy_d = (div_q != DIV_BASE);
    end
  end

  always_comb begin
    pc_d     = pc_q;
    acc_d    = acc_q;
    zero_d   = zero_q;
    neg_d    = neg_q;
    halt_d   = halt_q;
    status_d = status_q;
    if (ctl_i.accept) begin
      status_d = (req_i.command == CMD_EXEC && stopped) ? ST_IGNORED : ST_OK;
    end else if (ctl_i.exec) begin
      case (ir_q)
        OP_NOP: pc_d = pc_adv1;
        OP_STA: pc_d = pc_adv2;
        OP_LDA: begin
          acc_d = rdata_q;
          pc_d  = pc_adv2;
        end
        OP_ADD: begin
          acc_d = acc_q + rdata_q;
          pc_d  = pc_adv2;
        end
        OP_OR: begin
          acc_d = acc_q | rdata_q;
          pc_d  = pc_adv2;
        end
        OP_AND: begin
          acc_d = acc_q & rdata_q;
          pc_d  = pc_adv2;
        end
        OP_NOT: begin
          acc_d = ~acc_q;
          pc_d  = pc_adv1;
        end
        OP_JMP: pc_d = PW'(ea);
        OP_JN:  pc_d = neg_q ? PW'(ea) : pc_adv2;
        OP_JZ:  pc_d = zero_q ? PW'(ea) : pc_adv2;
        OP_HLT: halt_d = 1'b1;
        default: begin
          pc_d     = pc_adv1;
          status_d = ST_SKIP;
        end
      endcase
      if (op_class == CLS_LOAD || ir_q == OP_NOT) begin
        zero_d = (acc_d == '0);
        neg_d  = (acc_d & SIGN_MASK) != '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= '0;
      acc_q      <= '0;
      zero_q     <= 1'b0;
      neg_q      <= 1'b0;
      halt_q     <= 1'b0;
      mod_busy_q <= 1'b0;
    end else begin
      pc_q       <= pc_d;
      acc_q      <= acc_d;
      zero_q     <= zero_d;
      neg_q      <= neg_d;
      halt_q     <= halt_d;
      mod_busy_q <= mod_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q    <= mod_d;
    div_q    <= div_d;
    status_q <= status_d;
    if (ctl_i.accept) begin
      data_q <= req_i.word_data;
      rd_q   <= '0;
    end else if (ctl_i.rd_load) begin
      rd_q <= rdata_q;
    end
    if (ctl_i.ir_load) begin
      ir_q <= rdata_q;
    end
  end

  assign sts_o.mod_done = ~mod_busy_q;
  assign sts_o.stopped  = stopped;
  assign sts_o.op_class = op_class;

  assign rsp_o.program_counter = PC_W'(pc_q);
  assign rsp_o.accumulator     = acc_q;
  assign rsp_o.zero_flag       = zero_q;
  assign rsp_o.negative_flag   = neg_q;
  assign rsp_o.stopped         = stopped;
  assign rsp_o.read_word       = rd_q;
  assign rsp_o.step_status     = status_q;

endmodule

// ----- hdl/acs_ctrl.sv -----
// ----------------------------------------------------------------------------
// acs_ctrl
// Command sequencer: memory access, fetch, operand reduction and execute.
// ----------------------------------------------------------------------------
module acs_ctrl
  import acs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [CMD_W-1:0] command_i,
  input  acs_sts_t         sts_i,
  output acs_ctl_t         ctl_o,
  output logic             busy,
  output logic             rsp_valid_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR_MOD,
    S_ACCESS_WAIT,
    S_FETCH_OP,
    S_FETCH_OPND,
    S_OPND_LOAD,
    S_EA_MOD,
    S_DATA_WAIT,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ctl_o   = '{accept: 1'b0, mem_re: 1'b0, raddr_sel: RADDR_EA, mem_we: 1'b0,
                wdata_sel: WDATA_REQ, ir_load: 1'b0, opnd_load: 1'b0,
                rd_load: 1'b0, exec: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.accept = 1'b1;
          cmd_d        = command_i;
          case (command_i)
            CMD_WRITE, CMD_READ: state_d = S_ADDR_MOD;
            CMD_EXEC:            state_d = sts_i.stopped ? S_DONE : S_FETCH_OP;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_ADDR_MOD: begin
        if (sts_i.mod_done) begin
          if (cmd_q == CMD_WRITE) begin
            ctl_o.mem_we = 1'b1;
            state_d      = S_DONE;
          end else begin
            ctl_o.mem_re = 1'b1;
            state_d      = S_ACCESS_WAIT;
          end
        end
      end
      S_ACCESS_WAIT: begin
        ctl_o.rd_load = 1'b1;
        state_d       = S_DONE;
      end
      S_FETCH_OP: begin
        ctl_o.mem_re    = 1'b1;
        ctl_o.raddr_sel = RADDR_PC;
        state_d         = S_FETCH_OPND;
      end
      S_FETCH_OPND: begin
        ctl_o.mem_re    = 1'b1;
        ctl_o.raddr_sel = RADDR_PC1;
        ctl_o.ir_load   = 1'b1;
        state_d         = S_OPND_LOAD;
      end
      S_OPND_LOAD: begin
        ctl_o.opnd_load = 1'b1;
        state_d         = S_EA_MOD;
      end
      S_EA_MOD: begin
        if (sts_i.mod_done) begin
          case (sts_i.op_class)
            CLS_LOAD: begin
              ctl_o.mem_re = 1'b1;
              state_d      = S_DATA_WAIT;
            end
            CLS_STORE: begin
              ctl_o.mem_we    = 1'b1;
              ctl_o.wdata_sel = WDATA_ACC;
              ctl_o.exec      = 1'b1;
              state_d         = S_DONE;
            end
            default: begin
              ctl_o.exec = 1'b1;
              state_d    = S_DONE;
            end
          endcase
        end
      end
      S_DATA_WAIT: begin
        ctl_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_WRITE;
      busy        <= 1'b0;
      rsp_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      busy        <= (state_d != S_IDLE);
      rsp_valid_o <= (state_d == S_DONE);
    end
  end

endmodule

// ----- hdl/accumulator_cpu_step_core.sv -----
// ----------------------------------------------------------------------------
// accumulator_cpu_step_core
// Accumulator CPU with a word memory; one command per request.
// ----------------------------------------------------------------------------
//  channel   | ports                  | handshake
//  ----------+------------------------+-------------------------------
//  request   | req_i                  | taken when start & !busy
//  result    | rsp_o                  | rsp_valid_o, one cycle, no stall
//
//  To the result strobe: a write reduces its address; a read also waits for
//  data; execute fetches opcode and operand, reduces the operand and, for
//  LDA/ADD/OR/AND, reads data; ignored or unused commands skip these. Busy
//  drops the cycle after the strobe. Reads are serial on the single memory
//  port. Reset clears PC, accumulator, flags and halt; memory holds garbage
//  until written.
// ----------------------------------------------------------------------------
module accumulator_cpu_step_core
  import acs_pkg::*;
#(
  parameter int MEM_DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  acs_req_t req_i,
  output acs_rsp_t rsp_o,
  output logic     rsp_valid_o
);

  acs_ctl_t ctl;
  acs_sts_t sts;

  acs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .command_i   (req_i.command),
    .sts_i       (sts),
    .ctl_o       (ctl),
    .busy        (busy),
    .rsp_valid_o (rsp_valid_o)
  );

  acs_datapath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule
